// ===== rtl/sorted_key_multimap_table_assert.svh =====
// ----------------------------------------------------------------------------
// sorted key multimap table assertion macros
// shared concurrent assertion forms, sampled on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_MULTIMAP_TABLE_ASSERT_SVH
`define SORTED_KEY_MULTIMAP_TABLE_ASSERT_SVH

// same-cycle implication
`define SKMT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SKMT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/skmt_pkg.sv =====
// ----------------------------------------------------------------------------
// skmt_pkg
// types and codes shared by the sorted key multimap table and its cells
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package skmt_pkg;

  localparam int KEY_BITS  = 32;
  localparam int INPAY_BITS = 16;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_INSERTED  = 2'd0;
  localparam logic [1:0] STATUS_REMOVED   = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_DELETE
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS,
    ST_REM,
    ST_RESP
  } state_t;

  typedef struct packed {
    cell_cmd_t             cmd;
    logic [KEY_BITS-1:0]   key;
  } cell_ctrl_t;

  typedef struct packed {
    logic gt;
    logic ge;
    logic eq;
    logic mark;
  } cell_flags_t;

endpackage

`default_nettype wire

// ===== rtl/skmt_cell.sv =====
// ----------------------------------------------------------------------------
// skmt_cell
// one slot of the sorted chain: holds a key and payload, compares against the
// broadcast key and shifts right on insert or left on delete
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skmt_cell #(
  parameter int PAYLOAD_BITS = 16
) (
  input  wire                            clk,
  input  skmt_pkg::cell_ctrl_t           ctrl,
  input  wire [PAYLOAD_BITS-1:0]         new_pay,
  input  wire                            valid,
  input  wire [skmt_pkg::KEY_BITS-1:0]   left_key,
  input  wire [PAYLOAD_BITS-1:0]         left_pay,
  input  skmt_pkg::cell_flags_t          left_flags,
  input  wire [skmt_pkg::KEY_BITS-1:0]   right_key,
  input  wire [PAYLOAD_BITS-1:0]         right_pay,
  output logic [skmt_pkg::KEY_BITS-1:0]  key_o,
  output logic [PAYLOAD_BITS-1:0]        pay_o,
  output skmt_pkg::cell_flags_t          flags
);
  import skmt_pkg::*;

  logic [KEY_BITS-1:0]     key_r, key_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;
  logic                    take_new;

  always_comb begin
    // empty slots rank above every key
    flags.gt   = !valid || (key_r > ctrl.key);
    flags.eq   = valid && (key_r == ctrl.key);
    flags.ge   = flags.gt || flags.eq;
    take_new   = !left_flags.gt && flags.gt;
    flags.mark = (ctrl.cmd == CMD_INSERT) ? take_new : (flags.eq && !left_flags.eq);
  end

  always_comb begin
    key_nxt = key_r;
    pay_nxt = pay_r;
    unique case (ctrl.cmd)
      CMD_INSERT: begin
        if (left_flags.gt) begin
          key_nxt = left_key;
          pay_nxt = left_pay;
        end else if (take_new) begin
          key_nxt = ctrl.key;
          pay_nxt = new_pay;
        end
      end
      CMD_DELETE: begin
        if (flags.ge) begin
          key_nxt = right_key;
          pay_nxt = right_pay;
        end
      end
      default: begin
        key_nxt = key_r;
        pay_nxt = pay_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    pay_r <= pay_nxt;
  end

  assign key_o = key_r;
  assign pay_o = pay_r;

endmodule

`default_nettype wire

// ===== rtl/sorted_key_multimap_table.sv =====
// ----------------------------------------------------------------------------
// sorted_key_multimap_table
// sorted (key, payload) table with duplicate keys, kept in a chain of cells
//
//   channel   ports                                   handshake
//   input     in_action in_key_id in_payload          start && !busy
//   result    out_status out_position                 out_valid, one cycle
//             out_removed_count out_occupancy
//
// insert: the chain shifts in ST_INS, then the result shows in ST_RESP
// remove: one chain shift per deleted entry in ST_REM, then the result in ST_RESP
// full insert: straight to ST_RESP, with no chain shift
// a new transaction is taken in the result cycle; the receiver cannot stall
// synchronous reset empties the table at once, no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_key_multimap_table_assert.svh"

module sorted_key_multimap_table #(
  parameter int CAPACITY     = 64,
  parameter int PAYLOAD_BITS = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  wire                              in_action,
  input  wire [skmt_pkg::KEY_BITS-1:0]     in_key_id,
  input  wire [skmt_pkg::INPAY_BITS-1:0]   in_payload,
  output logic                             out_valid,
  output logic [1:0]                       out_status,
  output logic [6:0]                       out_position,
  output logic [6:0]                       out_removed_count,
  output logic [6:0]                       out_occupancy
);
  import skmt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        rem_r, rem_nxt;
  logic [IDX_W-1:0]        pos_r, pos_nxt;
  logic [1:0]              st_r, st_nxt;
  logic                    act_r;
  logic [KEY_BITS-1:0]     key_r;
  logic [INPAY_BITS-1:0]   pay_r;

  cell_ctrl_t              ctrl;
  logic                    accept;
  logic                    is_full;
  logic                    any_eq;
  logic [IDX_W-1:0]        mark_idx;

  logic [KEY_BITS-1:0]     key_w   [CAPACITY];
  logic [PAYLOAD_BITS-1:0] pay_w   [CAPACITY];
  cell_flags_t             flags_w [CAPACITY];
  logic [CAPACITY-1:0]     valid_w;
  logic [CAPACITY-1:0]     eq_vec;
  logic [CAPACITY-1:0]     mark_vec;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [KEY_BITS-1:0]     lk, rk;
      logic [PAYLOAD_BITS-1:0] lp, rp;
      cell_flags_t             lf;

      if (gi == 0) begin : g_first
        assign lk = '0;
        assign lp = '0;
        assign lf = '0;
      end else begin : g_mid
        assign lk = key_w[gi-1];
        assign lp = pay_w[gi-1];
        assign lf = flags_w[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign rk = '0;
        assign rp = '0;
      end else begin : g_inner
        assign rk = key_w[gi+1];
        assign rp = pay_w[gi+1];
      end

      assign valid_w[gi]  = count_r > CNT_W'(gi);
      assign eq_vec[gi]   = flags_w[gi].eq;
      assign mark_vec[gi] = flags_w[gi].mark;

      skmt_cell #(
        .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .new_pay    (PAYLOAD_BITS'(pay_r)),
        .valid      (valid_w[gi]),
        .left_key   (lk),
        .left_pay   (lp),
        .left_flags (lf),
        .right_key  (rk),
        .right_pay  (rp),
        .key_o      (key_w[gi]),
        .pay_o      (pay_w[gi]),
        .flags      (flags_w[gi])
      );
    end
  endgenerate

  always_comb begin
    mark_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (mark_vec[i]) begin
        mark_idx = mark_idx | IDX_W'(i);
      end
    end
  end

  assign any_eq  = |eq_vec;
  assign is_full = count_r == CNT_W'(CAPACITY);
  assign accept  = start && !busy;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE, ST_RESP: begin
        if (accept) begin
          if (in_action == ACT_REMOVE) begin
            state_nxt = ST_REM;
          end else if (is_full) begin
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_INS;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_INS: begin
        state_nxt = ST_RESP;
      end
      ST_REM: begin
        if (!any_eq) begin
          state_nxt = ST_RESP;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    busy      = 1'b0;
    out_valid = 1'b0;
    ctrl.cmd  = CMD_HOLD;
    ctrl.key  = key_r;
    unique case (state_r)
      ST_INS: begin
        busy     = 1'b1;
        ctrl.cmd = CMD_INSERT;
      end
      ST_REM: begin
        busy     = 1'b1;
        ctrl.cmd = any_eq ? CMD_DELETE : CMD_HOLD;
      end
      ST_RESP: begin
        out_valid = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // datapath
  always_comb begin
    count_nxt = count_r;
    rem_nxt   = rem_r;
    pos_nxt   = pos_r;
    st_nxt    = st_r;
    if (accept) begin
      rem_nxt = '0;
      pos_nxt = '0;
      st_nxt  = STATUS_FULL;
    end else if (state_r == ST_INS) begin
      count_nxt = count_r + CNT_W'(1);
      pos_nxt   = mark_idx;
      st_nxt    = STATUS_INSERTED;
    end else if (state_r == ST_REM) begin
      if (any_eq) begin
        count_nxt = count_r - CNT_W'(1);
        rem_nxt   = rem_r + CNT_W'(1);
        if (rem_r == '0) begin
          pos_nxt = mark_idx;
        end
      end else begin
        st_nxt = (rem_r != '0) ? STATUS_REMOVED : STATUS_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    pos_r <= pos_nxt;
    st_r  <= st_nxt;
    if (accept) begin
      act_r <= in_action;
      key_r <= in_key_id;
      pay_r <= in_payload;
    end
  end

  assign out_status        = st_r;
  assign out_position      = 7'(pos_r);
  assign out_removed_count = 7'(rem_r);
  assign out_occupancy     = 7'(count_r);

  `SKMT_ASSERT_IMP(a_count_range, 1'b1, count_r <= CNT_W'(CAPACITY))
  `SKMT_ASSERT_IMP(a_mark_onehot, 1'b1, $onehot0(mark_vec))
  `SKMT_ASSERT_NXT(a_ins_grows, state_r == ST_INS, count_r == $past(count_r) + CNT_W'(1))
  `SKMT_ASSERT_IMP(a_removed_nonzero, out_valid && out_status == STATUS_REMOVED,
                   rem_r != '0 && act_r == ACT_REMOVE)

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// testbench for sorted_key_multimap_table: random and directed insert and
// remove transactions, with each result checked against a sorted-table
// predictor kept inside the scoreboard
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import skmt_pkg::*;

  localparam int TABLE_DEPTH = 64;

  class multimap_scoreboard;
    typedef struct {
      logic [1:0] status;
      logic [6:0] position;
      logic [6:0] removed_count;
      logic [6:0] occupancy;
    } table_result_t;

    logic [KEY_BITS-1:0]   slot_key [TABLE_DEPTH];
    logic [INPAY_BITS-1:0] slot_pay [TABLE_DEPTH];
    int unsigned           fill;
    table_result_t         awaited [$];
    int                    errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    // first slot whose key is above (upper) or not below the given key
    function int unsigned key_bound(logic [KEY_BITS-1:0] key, bit upper);
      int unsigned idx;
      idx = 0;
      while (idx < fill && (upper ? slot_key[idx] <= key : slot_key[idx] < key)) idx++;
      return idx;
    endfunction

    function void note_request(logic act, logic [KEY_BITS-1:0] key,
                               logic [INPAY_BITS-1:0] pay);
      table_result_t r;
      int unsigned lo, hi, gone;
      r.status        = STATUS_INSERTED;
      r.position      = '0;
      r.removed_count = '0;
      if (act == ACT_INSERT) begin
        if (fill >= TABLE_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          lo = key_bound(key, 1'b1);
          for (int unsigned i = fill; i > lo; i--) begin
            slot_key[i] = slot_key[i-1];
            slot_pay[i] = slot_pay[i-1];
          end
          slot_key[lo] = key;
          slot_pay[lo] = pay;
          fill++;
          r.position = lo[6:0];
        end
      end else begin
        lo = key_bound(key, 1'b0);
        hi = key_bound(key, 1'b1);
        if (lo == hi) begin
          r.status = STATUS_NOT_FOUND;
        end else begin
          gone = hi - lo;
          for (int unsigned i = lo; i + gone < fill; i++) begin
            slot_key[i] = slot_key[i+gone];
            slot_pay[i] = slot_pay[i+gone];
          end
          fill -= gone;
          r.status        = STATUS_REMOVED;
          r.position      = lo[6:0];
          r.removed_count = gone[6:0];
        end
      end
      r.occupancy = fill[6:0];
      awaited.push_back(r);
    endfunction

    function void field_ok(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] status, logic [6:0] position,
                               logic [6:0] removed_count, logic [6:0] occupancy);
      table_result_t e;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d position %0d",
                 $time, status, position);
        errors++;
        return;
      end
      e = awaited.pop_front();
      field_ok("status", e.status, status);
      field_ok("position", e.position, position);
      field_ok("removed_count", e.removed_count, removed_count);
      field_ok("occupancy", e.occupancy, occupancy);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  in_action = ACT_INSERT;
  logic [KEY_BITS-1:0]   in_key_id = '0;
  logic [INPAY_BITS-1:0] in_payload = '0;
  wire                   busy;
  wire                   out_valid;
  wire  [1:0]            out_status;
  wire  [6:0]            out_position;
  wire  [6:0]            out_removed_count;
  wire  [6:0]            out_occupancy;

  multimap_scoreboard sb = new();

  sorted_key_multimap_table #(
    .CAPACITY    (TABLE_DEPTH),
    .PAYLOAD_BITS(INPAY_BITS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_key_id        (in_key_id),
    .in_payload       (in_payload),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_position     (out_position),
    .out_removed_count(out_removed_count),
    .out_occupancy    (out_occupancy)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // note accepted transactions, then check results
  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_request(in_action, in_key_id, in_payload);
    if (rst_n && out_valid)
      sb.check_result(out_status, out_position, out_removed_count, out_occupancy);
  end

  task automatic send_op(input logic act, input logic [KEY_BITS-1:0] key,
                         input logic [INPAY_BITS-1:0] pay, input bit may_idle);
    int gap;
    if (may_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_action  <= act;
    in_key_id  <= key;
    in_payload <= pay;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // keys present in the table, corner keys, or anything
  function automatic logic [KEY_BITS-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4 && sb.fill > 0) return sb.slot_key[$urandom_range(0, sb.fill - 1)];
    if (r < 7) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h7FFF_FFFF;
        default: return 32'h8000_0000;
      endcase
    end
    return $urandom;
  endfunction

  task automatic run_phase(input int count, input int insert_pct, input bit may_idle);
    logic act;
    for (int i = 0; i < count; i++) begin
      act = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
      send_op(act, pick_key(), INPAY_BITS'($urandom_range(0, 65535)), may_idle);
    end
  endtask

  initial begin
    logic [KEY_BITS-1:0] run_key;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners, back to back
    send_op(ACT_REMOVE, 32'h0000_0000, 16'h0000, 1'b0);
    send_op(ACT_INSERT, 32'h8000_0000, 16'h0000, 1'b0);
    send_op(ACT_INSERT, 32'h0000_0000, 16'hFFFF, 1'b0);
    send_op(ACT_INSERT, 32'hFFFF_FFFF, 16'hAAAA, 1'b0);
    send_op(ACT_INSERT, 32'hFFFF_FFFF, 16'h5555, 1'b0);
    send_op(ACT_INSERT, 32'h0000_0000, 16'h1234, 1'b0);
    send_op(ACT_INSERT, 32'h8000_0000, 16'hFFFF, 1'b0);
    send_op(ACT_INSERT, 32'h7FFF_FFFF, 16'h0F0F, 1'b0);
    send_op(ACT_REMOVE, 32'h1234_5678, 16'hFFFF, 1'b0);
    send_op(ACT_REMOVE, 32'hFFFF_FFFF, 16'h0000, 1'b0);
    send_op(ACT_REMOVE, 32'h0000_0000, 16'h0000, 1'b0);
    send_op(ACT_REMOVE, 32'h8000_0000, 16'h0000, 1'b0);
    send_op(ACT_REMOVE, 32'h7FFF_FFFF, 16'h0000, 1'b0);
    send_op(ACT_REMOVE, 32'hFFFF_FFFF, 16'h0000, 1'b0);
    send_op(ACT_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    send_op(ACT_REMOVE, 32'hFFFF_FFFF, 16'h0000, 1'b0);

    // random phases
    run_phase(110, 90, 1'b1);
    run_phase(150, 50, 1'b1);
    run_phase(80, 15, 1'b1);
    while (sb.fill > 0)
      send_op(ACT_REMOVE, sb.slot_key[0], INPAY_BITS'($urandom_range(0, 65535)), 1'b1);
    run_key = $urandom;
    repeat (70) send_op(ACT_INSERT, run_key, INPAY_BITS'($urandom_range(0, 65535)), 1'b1);
    send_op(ACT_REMOVE, run_key, INPAY_BITS'($urandom_range(0, 65535)), 1'b1);
    run_phase(150, 60, 1'b1);
    run_phase(100, 50, 1'b0);

    start <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/skmt_pkg.sv
rtl/skmt_cell.sv
rtl/sorted_key_multimap_table.sv
sim/tb_top.sv
